// ===== rtl/core/sli_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sli_pkg
// Shared types and codes for the sorted list block: request and result
// words, request modes and result status codes.
// ----------------------------------------------------------------------------
package sli_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int VAL_W     = 32;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_LIST   = 2'd2;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_DELETED  = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;
    localparam logic [2:0] ST_LISTED   = 3'd5;

    typedef struct packed {
        logic [1:0]              mode;
        logic signed [VAL_W-1:0] item_value;
    } t_in;

    typedef struct packed {
        logic [2:0]              status;
        logic signed [VAL_W-1:0] out_value;
        logic                    last;
    } t_out;

endpackage

// ===== rtl/core/sorted_list_insert_delete_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_insert_delete_top
// Bounded table of signed values kept in ascending order in one RAM, with
// insert, delete-first-equal and list requests.
// ----------------------------------------------------------------------------
// A request word is taken when start is high and busy is low. Results come
// out one per cycle on o_result, marked by o_valid, and must be taken on the
// cycle they appear; the last result of a request has last set. The table
// sits in a single RAM with one read and one write port, and each step reads
// one entry and writes at most one back. An insert on an empty or full table
// answers from the idle state; else it walks down from the top, moving each
// larger entry up, and writes the new value into the gap. A delete on an
// empty table answers from the idle state; else it scans up to the first
// match and then moves the later entries down, so it visits every entry
// whether or not a match is found. A list gives one result per entry; an
// empty list gives a single empty status result. Requests
// with an unused mode are dropped without a result.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete_top #(
    parameter int DEPTH = sli_pkg::DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  sli_pkg::t_in  i_item,
    output logic          o_valid,
    output sli_pkg::t_out o_result
);

    localparam int AW = $clog2(DEPTH);
    localparam int IW = $clog2(DEPTH + 1);
    localparam int VW = sli_pkg::VAL_W;
    localparam logic [IW-1:0] FULL_CNT = IW'(DEPTH);
    localparam logic [IW-1:0] ONE      = IW'(1);
    localparam logic [IW-1:0] TWO      = IW'(2);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_INS     = 3'd1;
    localparam logic [2:0] S_INS_FIN = 3'd2;
    localparam logic [2:0] S_DSR     = 3'd3;
    localparam logic [2:0] S_DSH     = 3'd4;
    localparam logic [2:0] S_LST     = 3'd5;

    logic [2:0]           r_state, n_state;
    logic [IW-1:0]        r_count, n_count;
    logic [IW-1:0]        r_idx, n_idx;
    logic signed [VW-1:0] r_val, n_val;
    logic                 r_valid, n_valid;
    sli_pkg::t_out        r_result, n_result;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [VW-1:0] w_wdata;
    logic [IW-1:0] w_raddr;
    logic [VW-1:0] w_rdata;

    sli_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr[AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_val    = r_val;
        n_valid  = 1'b0;
        n_result = r_result;
        w_we     = 1'b0;
        w_waddr  = r_idx[AW-1:0];
        w_wdata  = w_rdata;
        w_raddr  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_val = i_item.item_value;
                    n_idx = '0;
                    unique case (i_item.mode) inside
                        sli_pkg::MODE_INSERT: begin
                            if (r_count == FULL_CNT) begin
                                n_valid  = 1'b1;
                                n_result = '{sli_pkg::ST_FULL, i_item.item_value, 1'b1};
                            end else if (r_count == '0) begin
                                w_we     = 1'b1;
                                w_waddr  = '0;
                                w_wdata  = i_item.item_value;
                                n_count  = ONE;
                                n_valid  = 1'b1;
                                n_result = '{sli_pkg::ST_INSERTED, i_item.item_value, 1'b1};
                            end else begin
                                // walk down from the top, moving larger entries up
                                n_idx   = r_count;
                                w_raddr = r_count - ONE;
                                n_state = S_INS;
                            end
                        end
                        sli_pkg::MODE_DELETE, sli_pkg::MODE_LIST: begin
                            if (r_count == '0) begin
                                n_valid  = 1'b1;
                                n_result = '{sli_pkg::ST_EMPTY, i_item.item_value, 1'b1};
                            end else begin
                                n_state = (i_item.mode == sli_pkg::MODE_LIST) ? S_LST : S_DSR;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_INS: begin
                // read data is entry r_idx-1
                w_raddr = r_idx - TWO;
                w_we    = 1'b1;
                if ($signed(w_rdata) >= r_val) begin
                    w_wdata = w_rdata;
                    n_idx   = r_idx - ONE;
                    if (r_idx == ONE) begin
                        n_state = S_INS_FIN;
                    end
                end else begin
                    w_wdata  = r_val;
                    n_count  = r_count + ONE;
                    n_valid  = 1'b1;
                    n_result = '{sli_pkg::ST_INSERTED, r_val, 1'b1};
                    n_state  = S_IDLE;
                end
            end
            S_INS_FIN: begin
                w_we     = 1'b1;
                w_waddr  = '0;
                w_wdata  = r_val;
                n_count  = r_count + ONE;
                n_valid  = 1'b1;
                n_result = '{sli_pkg::ST_INSERTED, r_val, 1'b1};
                n_state  = S_IDLE;
            end
            S_DSR: begin
                // read data is entry r_idx; next entry requested alongside
                w_raddr = r_idx + ONE;
                if (w_rdata == r_val) begin
                    if (r_idx + ONE == r_count) begin
                        n_count  = r_count - ONE;
                        n_valid  = 1'b1;
                        n_result = '{sli_pkg::ST_DELETED, r_val, 1'b1};
                        n_state  = S_IDLE;
                    end else begin
                        n_state = S_DSH;
                    end
                end else if (r_idx + ONE == r_count) begin
                    n_valid  = 1'b1;
                    n_result = '{sli_pkg::ST_NOTFOUND, r_val, 1'b1};
                    n_state  = S_IDLE;
                end else begin
                    n_idx = r_idx + ONE;
                end
            end
            S_DSH: begin
                // read data is entry r_idx+1, moved down into r_idx
                w_raddr = r_idx + TWO;
                w_we    = 1'b1;
                if (r_idx + TWO == r_count) begin
                    n_count  = r_count - ONE;
                    n_valid  = 1'b1;
                    n_result = '{sli_pkg::ST_DELETED, r_val, 1'b1};
                    n_state  = S_IDLE;
                end else begin
                    n_idx = r_idx + ONE;
                end
            end
            S_LST: begin
                w_raddr  = r_idx + ONE;
                n_valid  = 1'b1;
                n_result = '{sli_pkg::ST_LISTED, $signed(w_rdata), (r_idx + ONE == r_count)};
                n_idx    = r_idx + ONE;
                if (r_idx + ONE == r_count) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_val    <= n_val;
        r_result <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // table never holds more than DEPTH entries
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count above depth");

    // a final word always leaves the block idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_result.last) |-> !busy)
        else $error("busy after final word");

    // only a list in progress gives non-final words
    a_nonlast_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_result.last) |-> (r_state == S_LST))
        else $error("non-final word outside list");

    // insert on a full table is refused on the next cycle
    a_full_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.mode == sli_pkg::MODE_INSERT && r_count == FULL_CNT)
        |=> (r_valid && r_result.status == sli_pkg::ST_FULL && r_count == FULL_CNT))
        else $error("full insert not refused");

    // count moves by at most one per cycle
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count == $past(r_count) || r_count == $past(r_count) + ONE
                            || r_count == $past(r_count) - ONE))
        else $error("entry count jumped");

endmodule

// ===== rtl/core/sli_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sli_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module sli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
